// ===== design/tccw_pkg.sv =====
`timescale 1ns / 1ps
// tccw_pkg: shared constants and types for the text console character writer.
// No dependencies; imported by text_console_char_writer and by the testbench.
package tccw_pkg;

   localparam int ROWS      = 25;
   localparam int COLS      = 80;
   localparam int TAB_WIDTH = 8;   // power of two
   localparam int CELLS     = ROWS * COLS;

   localparam int COL_W  = $clog2(COLS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int ADDR_W = $clog2(CELLS);
   localparam int POS_W  = 11;
   localparam int CELL_W = 16;
   localparam int SYM_W  = 8;
   localparam int ATTR_W = 8;
   localparam int KIND_W = 2;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_PAD_W  = RSP_DATA_W - (POS_W + CELL_W + 1);

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

   localparam logic [SYM_W-1:0] SYM_BS       = 8'h08;
   localparam logic [SYM_W-1:0] SYM_TAB      = 8'h09;
   localparam logic [SYM_W-1:0] SYM_LF       = 8'h0A;
   localparam logic [SYM_W-1:0] SYM_CR       = 8'h0D;
   localparam logic [SYM_W-1:0] SYM_SPACE    = 8'h20;
   localparam logic [SYM_W-1:0] SYM_PRINT_HI = 8'h7F;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUT   = 2'd0,
      KIND_CLEAR = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

endpackage

// ===== design/text_console_char_writer.sv =====
`timescale 1ns / 1ps
// text_console_char_writer: text console with a 16-bit cell screen memory.
// Depends on tccw_pkg and tccw_ram.
//
// Requests arrive on req_* (tuser = kind, tdata = symbol and cell index);
// each produces exactly one response on rsp_* carrying the cursor position,
// the read cell value and a scroll flag. csr_we/csr_wdata set the attribute
// byte used for written and blanked cells.
//
// Handling, one request at a time:
//   put without scroll, unused kind : response registered straight from the request
//   read                            : RAM read data register, then response register
//   put that scrolls                : screen contents moved up one row through the
//                                     memory, then the last row blanked
//   clear                           : one cell per cycle
// A new request is taken once the previous one is finished and the response
// register is empty or being drained in the same cycle.
//
// After reset the screen memory is swept to zero, one cell per cycle, and
// req_tready stays low meanwhile. A stalled response holds and blocks further
// requests until rsp_tready is seen.
module text_console_char_writer
   import tccw_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,   // [7:0] symbol, [18:8] cell_index
   input  logic [KIND_W-1:0]       req_tuser,   // [1:0] kind
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,   // [10:0] cursor_position,
                                                // [26:11] cell_value, [27] scrolled
   input  logic                    csr_we,
   input  logic [ATTR_W-1:0]       csr_wdata
);

   localparam logic [COL_W:0] TAB_MASK = ~((COL_W+1)'(TAB_WIDTH - 1));

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_BLANK,
      ST_CLEAR
   } state_type;

   state_type               state_ff, state_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic                    cp_valid_ff, cp_valid_in;
   logic [ADDR_W-1:0]       cp_dst_ff, cp_dst_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [ATTR_W-1:0]       attr_ff, attr_in;
   logic                    rd_oor_ff, rd_oor_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_waddr;
   logic [CELL_W-1:0]       ram_wdata;
   logic [ADDR_W-1:0]       ram_raddr;
   logic [CELL_W-1:0]       ram_rdata;

   logic                    accept;
   kind_type                req_kind;
   logic [SYM_W-1:0]        req_sym;
   logic [ADDR_W-1:0]       req_idx;
   logic                    idx_ok;
   logic [CELL_W-1:0]       blank;
   logic [POS_W-1:0]        pos_cur;
   logic [POS_W-1:0]        pos_put;

   logic [COL_W:0]          col_n;
   logic [ROW_W:0]          row_n;
   logic                    put_write;
   logic                    put_scroll;
   logic [COL_W-1:0]        put_col;
   logic [ROW_W-1:0]        put_row;

   tccw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_kind   = kind_type'(req_tuser);
   assign req_sym    = req_tdata[SYM_W-1:0];
   assign req_idx    = req_tdata[SYM_W +: ADDR_W];
   assign idx_ok     = req_idx < ADDR_W'(CELLS);
   assign blank      = {attr_ff, SYM_SPACE};
   assign pos_cur    = POS_W'(row_ff) * POS_W'(COLS) + POS_W'(col_ff);
   assign pos_put    = POS_W'(put_row) * POS_W'(COLS) + POS_W'(put_col);

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // cursor movement for a put
   always_comb begin
      col_n     = {1'b0, col_ff};
      row_n     = {1'b0, row_ff};
      put_write = 1'b0;
      case (req_sym)
         SYM_BS: begin
            if (col_ff != '0) begin
               col_n = col_n - 1'b1;
            end
         end
         SYM_TAB: begin
            col_n = (col_n & TAB_MASK) + (COL_W+1)'(TAB_WIDTH);
         end
         SYM_CR: begin
            col_n = '0;
         end
         SYM_LF: begin
            col_n = '0;
            row_n = row_n + 1'b1;
         end
         default: begin
            if (req_sym inside {[SYM_SPACE:SYM_PRINT_HI]}) begin
               put_write = 1'b1;
               col_n     = col_n + 1'b1;
            end
         end
      endcase
      if (col_n >= (COL_W+1)'(COLS)) begin
         col_n = '0;
         row_n = row_n + 1'b1;
      end
      put_scroll = row_n >= (ROW_W+1)'(ROWS);
      put_col    = col_n[COL_W-1:0];
      put_row    = put_scroll ? ROW_W'(ROWS - 1) : row_n[ROW_W-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      cp_valid_in  = 1'b0;
      cp_dst_in    = cp_dst_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      attr_in      = csr_we ? csr_wdata : attr_ff;
      rd_oor_in    = rd_oor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = addr_ff;
      ram_wdata    = blank;
      ram_raddr    = addr_ff;

      case (state_ff)
         ST_INIT: begin
            ram_we    = 1'b1;
            ram_wdata = '0;
            addr_in   = addr_ff + 1'b1;
            if (addr_ff == ADDR_W'(CELLS - 1)) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            ram_raddr = idx_ok ? req_idx : '0;
            if (accept) begin
               case (req_kind)
                  KIND_PUT: begin
                     ram_we    = put_write;
                     ram_waddr = pos_cur;
                     ram_wdata = {attr_ff, req_sym};
                     col_in    = put_col;
                     row_in    = put_row;
                     if (put_scroll) begin
                        addr_in  = ADDR_W'(COLS);
                        state_in = ST_COPY;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = {RSP_PAD_W'(0), 1'b0, CELL_W'(0), pos_put};
                     end
                  end
                  KIND_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     addr_in  = '0;
                     state_in = ST_CLEAR;
                  end
                  KIND_READ: begin
                     rd_oor_in = !idx_ok;
                     state_in  = ST_READ;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = {RSP_PAD_W'(0), 1'b0, CELL_W'(0), pos_cur};
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {RSP_PAD_W'(0), 1'b0, rd_oor_ff ? CELL_W'(0) : ram_rdata,
                            pos_cur};
            state_in     = ST_IDLE;
         end
         ST_COPY: begin
            cp_valid_in = 1'b1;
            cp_dst_in   = addr_ff - ADDR_W'(COLS);
            ram_we      = cp_valid_ff;
            ram_waddr   = cp_dst_ff;
            ram_wdata   = ram_rdata;
            addr_in     = addr_ff + 1'b1;
            if (addr_ff == ADDR_W'(CELLS - 1)) begin
               addr_in  = ADDR_W'(CELLS - COLS);
               state_in = ST_BLANK;
            end
         end
         ST_BLANK: begin
            ram_we = 1'b1;
            if (cp_valid_ff) begin
               ram_waddr = cp_dst_ff;
               ram_wdata = ram_rdata;
            end else begin
               addr_in = addr_ff + 1'b1;
               if (addr_ff == ADDR_W'(CELLS - 1)) begin
                  addr_in      = '0;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {RSP_PAD_W'(0), 1'b1, CELL_W'(0), pos_cur};
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_CLEAR: begin
            ram_we  = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == ADDR_W'(CELLS - 1)) begin
               addr_in      = '0;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {RSP_PAD_W'(0), 1'b0, CELL_W'(0), pos_cur};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
            addr_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         addr_ff      <= '0;
         cp_valid_ff  <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         attr_ff      <= ATTR_RESET;
         rd_oor_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         cp_valid_ff  <= cp_valid_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         attr_ff      <= attr_in;
         rd_oor_ff    <= rd_oor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cp_dst_ff   <= cp_dst_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff < ROW_W'(ROWS))
      else $error("cursor row out of range");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff < COL_W'(COLS))
      else $error("cursor column out of range");

   a_write_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ram_waddr < ADDR_W'(CELLS))
      else $error("screen write beyond last cell");

   a_scroll_home: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[POS_W + CELL_W]
         |-> rsp_data_ff[POS_W-1:0] == POS_W'(CELLS - COLS))
      else $error("scroll response without cursor at start of last row");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY || state_ff == ST_BLANK || state_ff == ST_CLEAR)
         |-> !rsp_valid_ff)
      else $error("response pending while screen sweep is running");

endmodule

// ===== design/tccw_ram.sv =====
`timescale 1ns / 1ps
// tccw_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== test/tb_text_console_char_writer.sv =====
`timescale 1ns / 1ps
// tb_text_console_char_writer: self-checking bench for the text console character writer.
// Depends on tccw_pkg and text_console_char_writer; keeps its own screen, cursor and
// attribute copy to predict every response, with random sender gaps and receiver stalls.
module tb_text_console_char_writer;
   import tccw_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam logic [SYM_W-1:0]  SYM_NUL     = 8'h00;
   localparam logic [SYM_W-1:0]  SYM_CTRL_HI = 8'h1F;
   localparam logic [SYM_W-1:0]  SYM_HIGH_LO = 8'h80;
   localparam logic [SYM_W-1:0]  SYM_HIGH_HI = 8'hFF;
   localparam int                SETTLE      = 8;
   localparam int                DRAIN_LIMIT = 20000;

   typedef struct packed {
      logic [POS_W-1:0]  cursor_position;
      logic [CELL_W-1:0] cell_value;
      logic              scrolled;
   } console_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [7:0] symbol, [18:8] cell_index
   logic [KIND_W-1:0]     req_tuser = '0;   // [1:0] kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // [10:0] cursor_position, [26:11] cell_value,
                                           // [27] scrolled
   logic                  csr_we = 1'b0;
   logic [ATTR_W-1:0]     csr_wdata = '0;

   logic [CELL_W-1:0] screen_model [CELLS];
   int                cursor_col_model;
   int                cursor_row_model;
   logic [ATTR_W-1:0] attr_model;

   console_result_type pending_console_results [$];
   int                 mismatch_count = 0;
   int                 counted_requests = 0;
   int                 burst_left = 0;
   int                 ready_tick = 0;

   text_console_char_writer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver stall pattern rotates through four modes
   always @(posedge clock) begin
      ready_tick <= ready_tick + 1;
      case ((ready_tick / 700) % 4)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         2: begin
            rsp_tready <= ((ready_tick % 7) > 2);
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 1) == 1);
         end
      endcase
   end

   function automatic logic [CELL_W-1:0] blank_cell_model();
      return {attr_model, SYM_SPACE};
   endfunction

   function automatic bit is_noop(logic [KIND_W-1:0] kind, logic [SYM_W-1:0] sym);
      if (kind == KIND_UNUSED)
         return 1'b1;
      if (kind != KIND_PUT)
         return 1'b0;
      if (sym == SYM_BS || sym == SYM_TAB || sym == SYM_CR || sym == SYM_LF)
         return 1'b0;
      return !(sym >= SYM_SPACE && sym <= SYM_PRINT_HI);
   endfunction

   function automatic console_result_type apply_console_request(logic [KIND_W-1:0] kind,
                                                                logic [SYM_W-1:0] sym,
                                                                logic [POS_W-1:0] idx);
      console_result_type res;
      res = '0;
      if (kind == KIND_PUT) begin
         if (sym == SYM_BS) begin
            if (cursor_col_model > 0)
               cursor_col_model--;
         end else if (sym == SYM_TAB) begin
            cursor_col_model = cursor_col_model + TAB_WIDTH - (cursor_col_model % TAB_WIDTH);
         end else if (sym == SYM_CR) begin
            cursor_col_model = 0;
         end else if (sym == SYM_LF) begin
            cursor_col_model = 0;
            cursor_row_model++;
         end else if (sym >= SYM_SPACE && sym <= SYM_PRINT_HI) begin
            screen_model[cursor_row_model * COLS + cursor_col_model] = {attr_model, sym};
            cursor_col_model++;
         end
         if (cursor_col_model >= COLS) begin
            cursor_col_model = 0;
            cursor_row_model++;
         end
         if (cursor_row_model >= ROWS) begin
            for (int i = 0; i < CELLS - COLS; i++)
               screen_model[i] = screen_model[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++)
               screen_model[i] = blank_cell_model();
            cursor_row_model = ROWS - 1;
            res.scrolled = 1'b1;
         end
      end else if (kind == KIND_CLEAR) begin
         for (int i = 0; i < CELLS; i++)
            screen_model[i] = blank_cell_model();
         cursor_col_model = 0;
         cursor_row_model = 0;
      end else if (kind == KIND_READ) begin
         if (idx < CELLS)
            res.cell_value = screen_model[idx];
      end
      res.cursor_position = POS_W'(cursor_row_model * COLS + cursor_col_model);
      return res;
   endfunction

   // sender: bursts of random length separated by random gaps
   task automatic send_request(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym,
                               input logic [POS_W-1:0] idx);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'b0, idx, sym};
      do @(posedge clock); while (req_tready !== 1'b1);
      pending_console_results.push_back(apply_console_request(kind, sym, idx));
      if (!is_noop(kind, sym))
         counted_requests++;
   endtask

   task automatic put_symbol(input logic [SYM_W-1:0] sym);
      send_request(KIND_PUT, sym, '0);
   endtask

   task automatic read_cell(input int idx);
      send_request(KIND_READ, SYM_W'($urandom_range(0, 255)), POS_W'(idx));
   endtask

   task automatic wait_for_idle();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_console_results.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_text_attribute(input logic [ATTR_W-1:0] attr);
      wait_for_idle();
      csr_we    <= 1'b1;
      csr_wdata <= attr;
      @(posedge clock);
      csr_we    <= 1'b0;
      attr_model = attr;
   endtask

   task automatic note_mismatch(input string what, input console_result_type exp_res,
                                input console_result_type got_res);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: expected pos=%0d cell=%h scrolled=%b, got pos=%0d cell=%h scrolled=%b",
                  $realtime, what, exp_res.cursor_position, exp_res.cell_value, exp_res.scrolled,
                  got_res.cursor_position, got_res.cell_value, got_res.scrolled);
   endtask

   always @(posedge clock) begin
      console_result_type got_res;
      console_result_type exp_res;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got_res.cursor_position = rsp_tdata[POS_W-1:0];
         got_res.cell_value      = rsp_tdata[POS_W +: CELL_W];
         got_res.scrolled        = rsp_tdata[POS_W + CELL_W];
         if (pending_console_results.size() == 0) begin
            note_mismatch("response with no request pending", '0, got_res);
         end else begin
            exp_res = pending_console_results.pop_front();
            if (got_res.cursor_position !== exp_res.cursor_position)
               note_mismatch("cursor_position", exp_res, got_res);
            else if (got_res.cell_value !== exp_res.cell_value)
               note_mismatch("cell_value", exp_res, got_res);
            else if (got_res.scrolled !== exp_res.scrolled)
               note_mismatch("scrolled", exp_res, got_res);
         end
      end
   end

   // reset contents, range edges of read, and every special symbol
   task automatic test_reset_and_symbols();
      read_cell(0);
      read_cell(CELLS - 1);
      read_cell(CELLS);
      put_symbol(SYM_SPACE);
      put_symbol(SYM_PRINT_HI);
      put_symbol(SYM_HIGH_LO);
      put_symbol(SYM_HIGH_HI);
      put_symbol(SYM_NUL);
      put_symbol(SYM_CTRL_HI);
      put_symbol(SYM_BS);
      put_symbol(SYM_CR);
      put_symbol(SYM_BS);
      put_symbol(SYM_TAB);
      put_symbol(8'h41);
      put_symbol(SYM_TAB);
      put_symbol(SYM_LF);
      send_request(KIND_UNUSED, 8'hFF, '1);
      read_cell(0);
      read_cell(1);
      read_cell(8);
   endtask

   // tabs run off the end of the line, then a clear with a new attribute
   task automatic test_wrap_and_clear();
      set_text_attribute(8'hA5);
      repeat (COLS / TAB_WIDTH) put_symbol(SYM_TAB);
      send_request(KIND_CLEAR, '0, '0);
      read_cell(0);
      read_cell(CELLS - 1);
   endtask

   task automatic random_text_line();
      int len;
      int pick;
      logic [SYM_W-1:0] sym;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 20);
      repeat (len) begin
         pick = $urandom_range(0, 99);
         if (pick < 90)      sym = SYM_W'($urandom_range(SYM_SPACE, SYM_PRINT_HI));
         else if (pick < 93) sym = SYM_TAB;
         else if (pick < 95) sym = SYM_BS;
         else if (pick < 97) sym = SYM_W'($urandom_range(SYM_HIGH_LO, SYM_HIGH_HI));
         else                sym = SYM_W'($urandom_range(SYM_NUL, SYM_CTRL_HI));
         put_symbol(sym);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         put_symbol(SYM_LF);
      end else if (pick < 85) begin
         put_symbol(SYM_CR);
         put_symbol(SYM_LF);
      end
   endtask

   task automatic random_reads();
      int pos;
      int pick;
      repeat ($urandom_range(1, 4)) begin
         pos  = cursor_row_model * COLS + cursor_col_model;
         pick = $urandom_range(0, 3);
         if (pick < 2)
            read_cell(pos - $urandom_range(0, (pos < 240) ? pos : 240));
         else if (pick == 2)
            read_cell($urandom_range(0, CELLS - 1));
         else
            read_cell($urandom_range(0, 2047));
      end
   endtask

   task automatic test_random_traffic(input logic [ATTR_W-1:0] attr, input int quota);
      int target;
      int pick;
      set_text_attribute(attr);
      target = counted_requests + quota;
      while (counted_requests < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            random_text_line();
         end else if (pick < 85) begin
            random_reads();
         end else if (pick < 95) begin
            repeat ($urandom_range(1, 3))
               send_request(KIND_W'($urandom_range(0, 3)), SYM_W'($urandom_range(0, 255)),
                            POS_W'($urandom_range(0, 2047)));
         end else begin
            repeat ($urandom_range(5, 30)) put_symbol(SYM_LF);
         end
      end
   endtask

   initial begin
      for (int i = 0; i < CELLS; i++)
         screen_model[i] = '0;
      cursor_col_model = 0;
      cursor_row_model = 0;
      attr_model       = ATTR_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_and_symbols();
      test_wrap_and_clear();
      test_random_traffic(8'h00, 200);
      test_random_traffic(8'hFF, 200);
      test_random_traffic(ATTR_W'($urandom_range(1, 254)), 200);
      test_random_traffic(ATTR_W'($urandom_range(1, 254)), 200);
      wait_for_idle();
      if (mismatch_count == 0 && pending_console_results.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
design/tccw_pkg.sv
design/tccw_ram.sv
design/text_console_char_writer.sv
test/tb_text_console_char_writer.sv
